/* sv/tsp_pkg.sv */
// shared types and constants for the texture slot pool
// no dependencies
`default_nettype none
package tsp_pkg;
    localparam int LEVEL0_SLOTS = 64;
    localparam int LEVEL1_SLOTS = 1024;
    localparam int OWNER_BITS   = 16;
    localparam int TIME_BITS    = 8;
    localparam int TOTAL_SLOTS  = LEVEL0_SLOTS + LEVEL1_SLOTS;
    localparam int IDX_W        = $clog2(TOTAL_SLOTS);
    localparam int HANDLE_W     = 11;
    localparam int WORD_W       = 1 + OWNER_BITS + TIME_BITS;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_TOUCH = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_LOOK,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic latch;
        logic clear;
        logic look;
        logic scan;
        logic fin_look;
        logic fin_free;
        logic fin_evict;
        logic fin_miss;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       in_range;
        logic [1:0] act;
        logic       scan_free;
        logic       scan_end;
    } stat_t;
endpackage
`default_nettype wire

/* sv/texture_slot_pool_lru.sv */
// top level of the texture slot pool with first-free and least-recently-used replacement
// depends on tsp_pkg, tsp_ctrl and tsp_datapath
// After reset the block clears the whole slot table and holds busy high while it does.
// A request is taken when start is high and busy low. Free and touch read the slot once
// (no read when the handle is out of range or the action is undefined); allocate reads the
// level's slots one per cycle from the slot memory, which has one read and one write port,
// stopping at the first free one or else at the level's last slot. The result shows
// for one cycle with done high and cannot be held off.
`default_nettype none
module texture_slot_pool_lru (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        action,
    input  wire logic                              level,
    input  wire logic [tsp_pkg::OWNER_BITS-1:0]    owner_id,
    input  wire logic [tsp_pkg::HANDLE_W-1:0]      slot_handle,
    input  wire logic [tsp_pkg::TIME_BITS-1:0]     use_time,
    output logic                                   done,
    output logic [tsp_pkg::HANDLE_W-1:0]           granted_handle,
    output logic                                   evicted,
    output logic [tsp_pkg::OWNER_BITS-1:0]         evicted_owner,
    output logic                                   status
);
    tsp_pkg::cmd_t  cmd;
    tsp_pkg::stat_t stat;

    tsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tsp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .level          (level),
        .owner_id       (owner_id),
        .slot_handle    (slot_handle),
        .use_time       (use_time),
        .done           (done),
        .granted_handle (granted_handle),
        .evicted        (evicted),
        .evicted_owner  (evicted_owner),
        .status         (status)
    );
endmodule
`default_nettype wire

/* sv/tsp_ctrl.sv */
// controller state machine for the texture slot pool
// depends on tsp_pkg
`default_nettype none
module tsp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  tsp_pkg::stat_t      stat,
    output tsp_pkg::cmd_t       cmd,
    output logic                busy
);
    tsp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            tsp_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = tsp_pkg::S_IDLE;
                end
            end
            tsp_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tsp_pkg::S_DECIDE;
                end
            end
            tsp_pkg::S_DECIDE:
            begin
                if (stat.act == tsp_pkg::ACT_ALLOC)
                begin
                    state_next = tsp_pkg::S_SCAN;
                end
                else if ((stat.act == tsp_pkg::ACT_FREE || stat.act == tsp_pkg::ACT_TOUCH)
                         && stat.in_range)
                begin
                    cmd.look   = 1'b1;
                    state_next = tsp_pkg::S_LOOK;
                end
                else
                begin
                    cmd.fin_miss = 1'b1;
                    state_next   = tsp_pkg::S_IDLE;
                end
            end
            tsp_pkg::S_LOOK:
            begin
                cmd.fin_look = 1'b1;
                state_next   = tsp_pkg::S_IDLE;
            end
            tsp_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_free)
                begin
                    cmd.fin_free = 1'b1;
                    state_next   = tsp_pkg::S_IDLE;
                end
                else if (stat.scan_end)
                begin
                    cmd.fin_evict = 1'b1;
                    state_next    = tsp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tsp_pkg::S_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

/* sv/tsp_datapath.sv */
// slot memory, scan counters and result registers for the texture slot pool
// depends on tsp_pkg
`default_nettype none
module tsp_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  tsp_pkg::cmd_t                          cmd,
    output tsp_pkg::stat_t                         stat,
    input  wire logic [1:0]                        action,
    input  wire logic                              level,
    input  wire logic [tsp_pkg::OWNER_BITS-1:0]    owner_id,
    input  wire logic [tsp_pkg::HANDLE_W-1:0]      slot_handle,
    input  wire logic [tsp_pkg::TIME_BITS-1:0]     use_time,
    output logic                                   done,
    output logic [tsp_pkg::HANDLE_W-1:0]           granted_handle,
    output logic                                   evicted,
    output logic [tsp_pkg::OWNER_BITS-1:0]         evicted_owner,
    output logic                                   status
);
    localparam int OW = tsp_pkg::OWNER_BITS;
    localparam int TW = tsp_pkg::TIME_BITS;
    localparam int IW = tsp_pkg::IDX_W;

    logic [tsp_pkg::WORD_W-1:0] mem [0:tsp_pkg::TOTAL_SLOTS-1];
    logic [tsp_pkg::WORD_W-1:0] rdata_reg;

    logic [1:0]                 action_reg;
    logic [OW-1:0]              owner_reg;
    logic [tsp_pkg::HANDLE_W-1:0] handle_reg;
    logic [TW-1:0]              time_reg;
    logic [IW-1:0]              addr_reg;
    logic [IW-1:0]              last_reg;
    logic                       pend_reg;
    logic [IW-1:0]              pend_idx_reg;
    logic                       have_best_reg;
    logic [TW-1:0]              best_t_reg;
    logic [IW-1:0]              best_idx_reg;
    logic [OW-1:0]              best_owner_reg;

    logic                       done_reg;
    logic [tsp_pkg::HANDLE_W-1:0] handle_out_reg;
    logic                       evicted_reg;
    logic [OW-1:0]              ev_owner_reg;
    logic                       status_reg;

    logic                       r_busy;
    logic [OW-1:0]              r_owner;
    logic [TW-1:0]              r_time;
    logic                       take_cur;
    logic [IW-1:0]              ev_idx;
    logic [OW-1:0]              ev_owner;
    logic [IW-1:0]              rd_addr;
    logic [IW-1:0]              look_idx;

    assign r_busy   = rdata_reg[tsp_pkg::WORD_W-1];
    assign r_owner  = rdata_reg[TW +: OW];
    assign r_time   = rdata_reg[TW-1:0];
    assign look_idx = handle_reg[IW-1:0];
    assign rd_addr  = cmd.look ? look_idx : addr_reg;
    assign take_cur = !have_best_reg || (r_time < best_t_reg);
    assign ev_idx   = take_cur ? pend_idx_reg : best_idx_reg;
    assign ev_owner = take_cur ? r_owner : best_owner_reg;

    assign stat.clr_last  = (addr_reg == IW'(tsp_pkg::TOTAL_SLOTS - 1));
    assign stat.in_range  = (handle_reg < tsp_pkg::HANDLE_W'(tsp_pkg::TOTAL_SLOTS));
    assign stat.act       = action_reg;
    assign stat.scan_free = pend_reg && !r_busy;
    assign stat.scan_end  = pend_reg && (pend_idx_reg == last_reg);

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (cmd.clear)
        begin
            mem[addr_reg] <= '0;
        end
        else if (cmd.fin_free)
        begin
            mem[pend_idx_reg] <= {1'b1, owner_reg, time_reg};
        end
        else if (cmd.fin_evict)
        begin
            mem[ev_idx] <= {1'b1, owner_reg, time_reg};
        end
        else if (cmd.fin_look && r_busy)
        begin
            if (action_reg == tsp_pkg::ACT_FREE)
            begin
                mem[look_idx] <= {1'b0, r_owner, r_time};
            end
            else
            begin
                mem[look_idx] <= {1'b1, r_owner, time_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            owner_reg  <= owner_id;
            handle_reg <= slot_handle;
            time_reg   <= use_time;
            last_reg   <= level ? IW'(tsp_pkg::TOTAL_SLOTS - 1)
                                : IW'(tsp_pkg::LEVEL0_SLOTS - 1);
        end
        if (cmd.scan && pend_reg && take_cur)
        begin
            best_t_reg     <= r_time;
            best_idx_reg   <= pend_idx_reg;
            best_owner_reg <= r_owner;
        end
        if (cmd.scan)
        begin
            pend_idx_reg <= addr_reg;
        end
        if (cmd.fin_free)
        begin
            handle_out_reg <= tsp_pkg::HANDLE_W'(pend_idx_reg);
            evicted_reg    <= 1'b0;
            ev_owner_reg   <= '0;
            status_reg     <= 1'b0;
        end
        else if (cmd.fin_evict)
        begin
            handle_out_reg <= tsp_pkg::HANDLE_W'(ev_idx);
            evicted_reg    <= 1'b1;
            ev_owner_reg   <= ev_owner;
            status_reg     <= 1'b0;
        end
        else if (cmd.fin_look || cmd.fin_miss)
        begin
            handle_out_reg <= handle_reg;
            evicted_reg    <= 1'b0;
            ev_owner_reg   <= '0;
            status_reg     <= cmd.fin_miss ? 1'b1 : !r_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            have_best_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin_free || cmd.fin_evict || cmd.fin_look || cmd.fin_miss;
            if (cmd.clear)
            begin
                addr_reg <= addr_reg + IW'(1);
            end
            else if (cmd.latch)
            begin
                addr_reg      <= level ? IW'(tsp_pkg::LEVEL0_SLOTS) : '0;
                pend_reg      <= 1'b0;
                have_best_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= 1'b1;
                if (addr_reg != last_reg)
                begin
                    addr_reg <= addr_reg + IW'(1);
                end
                if (pend_reg)
                begin
                    have_best_reg <= 1'b1;
                end
            end
        end
    end

    assign done           = done_reg;
    assign granted_handle = handle_out_reg;
    assign evicted        = evicted_reg;
    assign evicted_owner  = ev_owner_reg;
    assign status         = status_reg;
endmodule
`default_nettype wire

/* tb/sv/texture_slot_pool_lru_tb.sv */
// self-checking testbench for texture_slot_pool_lru: directed and random requests,
// a clocked driver and monitor, expected results computed by an in-bench slot table
// depends on tsp_pkg and texture_slot_pool_lru
`default_nettype none
module texture_slot_pool_lru_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNDEF = 2'd3;

    typedef struct {
        logic [1:0]                     act;
        logic                           lvl;
        logic [tsp_pkg::OWNER_BITS-1:0] owner;
        logic [tsp_pkg::HANDLE_W-1:0]   handle;
        logic [tsp_pkg::TIME_BITS-1:0]  t;
    } slot_req_t;

    typedef struct {
        logic [tsp_pkg::HANDLE_W-1:0]   handle;
        logic                           evicted;
        logic [tsp_pkg::OWNER_BITS-1:0] ev_owner;
        logic                           status;
    } slot_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] action = '0;
    logic level = 1'b0;
    logic [tsp_pkg::OWNER_BITS-1:0] owner_id = '0;
    logic [tsp_pkg::HANDLE_W-1:0] slot_handle = '0;
    logic [tsp_pkg::TIME_BITS-1:0] use_time = '0;
    logic done;
    logic [tsp_pkg::HANDLE_W-1:0] granted_handle;
    logic evicted;
    logic [tsp_pkg::OWNER_BITS-1:0] evicted_owner;
    logic status;

    slot_req_t req_q[$];
    slot_resp_t resp_q[$];
    int idle_pct = 0;
    int err_cnt = 0;

    logic                           tab_busy[tsp_pkg::TOTAL_SLOTS];
    logic [tsp_pkg::OWNER_BITS-1:0] tab_owner[tsp_pkg::TOTAL_SLOTS];
    logic [tsp_pkg::TIME_BITS-1:0]  tab_time[tsp_pkg::TOTAL_SLOTS];

    texture_slot_pool_lru dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .level(level), .owner_id(owner_id), .slot_handle(slot_handle),
        .use_time(use_time), .done(done), .granted_handle(granted_handle),
        .evicted(evicted), .evicted_owner(evicted_owner), .status(status)
    );

    always #4 clk = ~clk;

    function automatic slot_resp_t pool_update(slot_req_t r);
        slot_resp_t res;
        int base;
        int cnt;
        int pick;
        logic hit;
        res = '{r.handle, 1'b0, '0, 1'b0};
        hit = (r.handle < tsp_pkg::TOTAL_SLOTS) ? tab_busy[r.handle] : 1'b0;
        if (r.act == tsp_pkg::ACT_ALLOC)
        begin
            base = r.lvl ? tsp_pkg::LEVEL0_SLOTS : 0;
            cnt = r.lvl ? tsp_pkg::LEVEL1_SLOTS : tsp_pkg::LEVEL0_SLOTS;
            pick = -1;
            for (int i = 0; i < cnt; i++)
            begin
                if (pick < 0 && !tab_busy[base + i])
                    pick = base + i;
            end
            if (pick < 0)
            begin
                pick = base;
                for (int i = 1; i < cnt; i++)
                begin
                    if (tab_time[base + i] < tab_time[pick])
                        pick = base + i;
                end
                res.evicted = 1'b1;
                res.ev_owner = tab_owner[pick];
            end
            tab_busy[pick] = 1'b1;
            tab_owner[pick] = r.owner;
            tab_time[pick] = r.t;
            res.handle = pick[tsp_pkg::HANDLE_W-1:0];
        end
        else if (r.act == tsp_pkg::ACT_FREE)
        begin
            if (hit)
                tab_busy[r.handle] = 1'b0;
            res.status = !hit;
        end
        else if (r.act == tsp_pkg::ACT_TOUCH)
        begin
            if (hit)
                tab_time[r.handle] = r.t;
            res.status = !hit;
        end
        else
            res.status = 1'b1;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            slot_req_t nxt;
            if (start && !busy)
                resp_q.push_back(pool_update('{action, level, owner_id, slot_handle,
                                               use_time}));
            if (!start || !busy)
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = req_q.pop_front();
                    action <= nxt.act;
                    level <= nxt.lvl;
                    owner_id <= nxt.owner;
                    slot_handle <= nxt.handle;
                    use_time <= nxt.t;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            slot_resp_t e;
            if (resp_q.size() == 0)
            begin
                $error("result with no request pending");
                err_cnt++;
            end
            else
            begin
                e = resp_q.pop_front();
                if (granted_handle !== e.handle)
                begin
                    $error("granted_handle expected %0d got %0d", e.handle, granted_handle);
                    err_cnt++;
                end
                if (evicted !== e.evicted)
                begin
                    $error("evicted expected %0d got %0d", e.evicted, evicted);
                    err_cnt++;
                end
                if (evicted_owner !== e.ev_owner)
                begin
                    $error("evicted_owner expected %0d got %0d", e.ev_owner, evicted_owner);
                    err_cnt++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0d got %0d", e.status, status);
                    err_cnt++;
                end
            end
        end
    end

    task automatic send(logic [1:0] a, logic l, logic [tsp_pkg::OWNER_BITS-1:0] o,
                        logic [tsp_pkg::HANDLE_W-1:0] h, logic [tsp_pkg::TIME_BITS-1:0] t);
        req_q.push_back('{a, l, o, h, t});
        while (req_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic drain();
        while (req_q.size() > 0 || start || resp_q.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic [tsp_pkg::HANDLE_W-1:0] busy_handle(logic l);
        logic [tsp_pkg::HANDLE_W-1:0] h;
        h = '0;
        for (int k = 0; k < 8; k++)
        begin
            h = l ? tsp_pkg::HANDLE_W'(tsp_pkg::LEVEL0_SLOTS + $urandom_range(63))
                  : tsp_pkg::HANDLE_W'($urandom_range(63));
            if (tab_busy[h])
                break;
        end
        return h;
    endfunction

    function automatic int level1_count();
        int n;
        n = 0;
        for (int i = tsp_pkg::LEVEL0_SLOTS; i < tsp_pkg::TOTAL_SLOTS; i++)
            n += tab_busy[i];
        return n;
    endfunction

    task automatic random_req();
        int r;
        logic l;
        r = $urandom_range(99);
        l = 1'($urandom_range(1));
        if (r < 6)
            send(2'($urandom_range(3)), l, 16'($urandom), 11'($urandom), 8'($urandom));
        else if (r < 45)
            send(tsp_pkg::ACT_ALLOC, (level1_count() < 48) ? l : 1'b0, 16'($urandom),
                 11'($urandom), 8'($urandom));
        else if (r < 75)
            send(tsp_pkg::ACT_FREE, l, 16'($urandom), busy_handle(l), 8'($urandom));
        else
            send(tsp_pkg::ACT_TOUCH, l, 16'($urandom), busy_handle(l), 8'($urandom));
    endtask

    initial
    begin
        for (int i = 0; i < tsp_pkg::TOTAL_SLOTS; i++)
        begin
            tab_busy[i] = 1'b0;
            tab_owner[i] = '0;
            tab_time[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send(tsp_pkg::ACT_ALLOC, 1'b0, 16'h0000, 11'h000, 8'h00);
        send(tsp_pkg::ACT_ALLOC, 1'b0, 16'hffff, 11'h7ff, 8'hff);
        send(tsp_pkg::ACT_ALLOC, 1'b1, 16'h1234, 11'h000, 8'h80);
        send(tsp_pkg::ACT_FREE, 1'b0, 16'h0, 11'd0, 8'h0);
        send(tsp_pkg::ACT_FREE, 1'b0, 16'h0, 11'd0, 8'h0);
        send(tsp_pkg::ACT_TOUCH, 1'b0, 16'h0, 11'd1, 8'h7f);
        send(tsp_pkg::ACT_TOUCH, 1'b0, 16'h0, 11'd5, 8'h11);
        send(tsp_pkg::ACT_FREE, 1'b1, 16'hffff, 11'h7ff, 8'hff);
        send(tsp_pkg::ACT_TOUCH, 1'b0, 16'h0, 11'(tsp_pkg::TOTAL_SLOTS), 8'h01);
        send(ACT_UNDEF, 1'b1, 16'hffff, 11'd1, 8'hff);
        send(ACT_UNDEF, 1'b0, 16'h0, 11'h7ff, 8'h0);
        send(tsp_pkg::ACT_FREE, 1'b0, 16'h0, 11'(tsp_pkg::LEVEL0_SLOTS), 8'h0);
        // fill level 0, all with one time so eviction ties go to the lowest slot
        for (int i = 0; i < tsp_pkg::LEVEL0_SLOTS; i++)
            send(tsp_pkg::ACT_ALLOC, 1'b0, 16'(16'ha000 + i), 11'h0, 8'h40);
        send(tsp_pkg::ACT_ALLOC, 1'b0, 16'hbeef, 11'h0, 8'h41);
        send(tsp_pkg::ACT_TOUCH, 1'b0, 16'h0, 11'd3, 8'h00);
        send(tsp_pkg::ACT_ALLOC, 1'b0, 16'hcafe, 11'h0, 8'h50);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = (p == 1) ? 63 : (p == 3) ? 31 : 0;
            for (int i = 0; i < 105; i++)
                random_req();
            drain();
        end

        repeat (50) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
